// ===== rtl/i2cm_pkg.sv =====
// Shared types and constants for the I2C master controller.
`default_nettype none
package i2cm_pkg;

	typedef enum logic [2:0] {
		FUNC_TICK    = 3'd0,
		FUNC_PROBE   = 3'd1,
		FUNC_WRITE   = 3'd2,
		FUNC_REQUEST = 3'd3,
		FUNC_POP     = 3'd4,
		FUNC_STOP    = 3'd5
	} func_t;

	typedef enum logic [1:0] {
		STAT_NONE  = 2'd0,
		STAT_NACK  = 2'd1,
		STAT_SHORT = 2'd2
	} status_t;

	localparam logic CFG_TARGET_ADDRESS = 1'b0;
	localparam logic CFG_HALF_PERIOD    = 1'b1;

	localparam logic [15:0] HALF_PERIOD_RST = 16'd20;
	localparam logic [6:0]  TARGET_ADDR_RST = 7'd0;
	localparam logic [3:0]  BITS_PER_BYTE   = 4'd8;

	// ACK timeout is 20 half periods: hp*16 + hp*4
	localparam int unsigned ACK_SHIFT_HI = 4;
	localparam int unsigned ACK_SHIFT_LO = 2;
	localparam int unsigned ACK_W        = 21;

	typedef struct packed {
		logic       push;
		logic [7:0] push_data;
		logic       pop;
	} fifo_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/i2cm_rxfifo.sv =====
// Receive FIFO with registered read port for the I2C master controller.
`default_nettype none
module i2cm_rxfifo #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned LW    = 5
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire i2cm_pkg::fifo_ctl_t  ctl,
	output logic [7:0]                rd_data,
	output logic [LW-1:0]             count
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	logic [7:0]    mem [DEPTH];
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [LW-1:0] count_q;
	logic [7:0]    rd_q;
	logic          full;
	logic          empty;

	assign full  = (count_q == LW'(DEPTH));
	assign empty = (count_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (ctl.push && !full) begin
				tail_q  <= (tail_q == LAST) ? '0 : tail_q + AW'(1);
				count_q <= count_q + LW'(1);
			end else if (ctl.pop && !empty) begin
				head_q  <= (head_q == LAST) ? '0 : head_q + AW'(1);
				count_q <= count_q - LW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push && !full) begin
			mem[tail_q] <= ctl.push_data;
		end
		if (ctl.pop && !empty) begin
			rd_q <= mem[head_q];
		end
	end

	assign rd_data = rd_q;
	assign count   = count_q;

endmodule
`default_nettype wire

// ===== rtl/i2c_master_controller.sv =====
// Top level: seven-bit-address I2C master bus engine, one tick per request.
// A request's result sits in the output register the cycle after the request is accepted.
// Throughput: one request per cycle while the result is not stalled (s_tready = !m_valid_q || m_tready);
// the engine state and result register update together. Pop data comes from the receive FIFO's registered read
// port, loaded with the result. Reset (arst_n low, asynchronous): engine idle, bus closed, FIFO empty,
// target_address 0, half_period 20. FIFO contents are not cleared.
`default_nettype none
module i2c_master_controller #(
	parameter int unsigned RX_DEPTH = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [15:0]  s_tdata,   // cmd_data[7:0], sda_in[8], zero fill
	input  wire logic [2:0]   s_tuser,   // func[2:0]
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// scl_out[0], sda_pull_low[1], busy_res[2], done_res[3], status[5:4],
	// pop_data[13:6], rx_level[13+LW:14], bus_open[14+LW], zero fill
	output logic [((15 + $clog2(RX_DEPTH + 1) + 7) / 8) * 8 - 1:0] m_tdata,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic         cfg_index,
	input  wire logic [15:0]  cfg_data
);

	localparam int unsigned LW    = $clog2(RX_DEPTH + 1);
	localparam int unsigned OUT_W = ((15 + LW + 7) / 8) * 8;
	localparam int unsigned SUM_W = ((LW > 8) ? LW : 8) + 1;
	localparam int unsigned AW_W  = i2cm_pkg::ACK_W;

	typedef enum logic [4:0] {
		PH_IDLE, PH_START_A, PH_START_B, PH_START_C,
		PH_WBIT_SET, PH_WBIT_HI, PH_WBIT_LO,
		PH_ACK_SET, PH_ACK_WAIT, PH_ACK_LO,
		PH_RBIT_HI, PH_RBIT_LO,
		PH_MACK_SET, PH_MACK_HI, PH_MACK_LO,
		PH_STOP_A, PH_STOP_B, PH_STOP_C
	} phase_t;

	// configuration
	logic [6:0]  target_address_q;
	logic [15:0] half_period_q;

	// engine state
	phase_t            phase_q;
	logic [15:0]       delay_q;
	logic [3:0]        bit_idx_q;
	logic [7:0]        shift_q;
	logic [AW_W-1:0]   ack_wait_q;
	logic [7:0]        bytes_left_q;
	logic              start_done_q;
	logic [7:0]        pending_q;
	i2cm_pkg::func_t   cur_op_q;
	logic              addr_stage_q;
	logic              mack_q;
	logic              nack_q;

	// result register
	logic              m_valid_q;
	logic              scl_q;
	logic              pull_q;
	logic              busy_q;
	logic              done_q;
	i2cm_pkg::status_t status_q;
	logic              popped_q;

	// next values
	phase_t            ph;
	logic [15:0]       dly;
	logic [3:0]        bi;
	logic [7:0]        sh;
	logic [AW_W-1:0]   aw;
	logic [7:0]        bl;
	logic              sd;
	logic [7:0]        pend;
	i2cm_pkg::func_t   op;
	logic              as_n;
	logic              mk;
	logic              rc;
	logic              scl;
	logic              pull;
	logic              done;
	i2cm_pkg::status_t stat;
	logic              run_eng;
	logic              begin_cmd;
	i2cm_pkg::fifo_ctl_t fctl;

	logic [15:0]       hp;
	logic [AW_W-1:0]   ack_limit;
	logic [16:0]       dly_inc;
	logic [AW_W-1:0]   aw_inc;
	logic [SUM_W-1:0]  need;
	logic              shortage;
	logic              accept;
	phase_t            ph_seg;

	logic [2:0]        func;
	logic [7:0]        cmd_data;
	logic              sda_in;
	logic [7:0]        rd_data;
	logic [LW-1:0]     rx_count;
	i2cm_pkg::fifo_ctl_t fctl_acc;

	assign func     = s_tuser;
	assign cmd_data = s_tdata[7:0];
	assign sda_in   = s_tdata[8];

	assign s_tready  = !m_valid_q || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	assign hp        = (half_period_q == '0) ? 16'd1 : half_period_q;
	assign ack_limit = (AW_W'(hp) << i2cm_pkg::ACK_SHIFT_HI)
		+ (AW_W'(hp) << i2cm_pkg::ACK_SHIFT_LO);
	assign need      = SUM_W'(rx_count) + SUM_W'(cmd_data);
	assign shortage  = (need > SUM_W'(RX_DEPTH));

	always_comb begin
		ph        = phase_q;
		dly       = delay_q;
		bi        = bit_idx_q;
		sh        = shift_q;
		aw        = ack_wait_q;
		bl        = bytes_left_q;
		sd        = start_done_q;
		pend      = pending_q;
		op        = cur_op_q;
		as_n      = addr_stage_q;
		mk        = mack_q;
		rc        = nack_q;
		scl       = 1'b0;
		pull      = 1'b0;
		done      = 1'b0;
		stat      = i2cm_pkg::STAT_NONE;
		run_eng   = 1'b0;
		begin_cmd = 1'b0;
		fctl      = '0;
		dly_inc   = '0;
		aw_inc    = '0;
		ph_seg    = PH_IDLE;

		if (phase_q == PH_IDLE) begin
			scl = !start_done_q;
			case (func)
				i2cm_pkg::FUNC_POP: begin
					fctl.pop = (rx_count != '0);
					done     = 1'b1;
				end
				i2cm_pkg::FUNC_REQUEST: begin
					if (shortage) begin
						done = 1'b1;
						stat = i2cm_pkg::STAT_SHORT;
					end else begin
						begin_cmd = 1'b1;
					end
				end
				i2cm_pkg::FUNC_PROBE, i2cm_pkg::FUNC_WRITE, i2cm_pkg::FUNC_STOP: begin
					begin_cmd = 1'b1;
				end
				default: begin
				end
			endcase
			if (begin_cmd) begin
				op      = i2cm_pkg::func_t'(func);
				rc      = 1'b0;
				as_n    = 1'b0;
				dly     = '0;
				aw      = '0;
				run_eng = 1'b1;
				if (func == i2cm_pkg::FUNC_STOP) begin
					ph = PH_STOP_A;
				end else if (func == i2cm_pkg::FUNC_WRITE && start_done_q) begin
					pend = cmd_data;
					sh   = cmd_data;
					bi   = i2cm_pkg::BITS_PER_BYTE;
					ph   = PH_WBIT_SET;
				end else begin
					pend = cmd_data;
					bl   = cmd_data;
					ph   = PH_START_A;
				end
			end
		end else begin
			run_eng = 1'b1;
		end

		if (run_eng) begin
			ph_seg = ph;
			unique case (ph)
				PH_START_A, PH_ACK_WAIT, PH_RBIT_HI, PH_STOP_C: begin
					scl = 1'b1; pull = 1'b0;
				end
				PH_START_B, PH_STOP_B: begin
					scl = 1'b1; pull = 1'b1;
				end
				PH_START_C, PH_STOP_A: begin
					scl = 1'b0; pull = 1'b1;
				end
				PH_WBIT_SET, PH_WBIT_LO: begin
					scl = 1'b0; pull = !sh[7];
				end
				PH_WBIT_HI: begin
					scl = 1'b1; pull = !sh[7];
				end
				PH_MACK_SET, PH_MACK_LO: begin
					scl = 1'b0; pull = mk;
				end
				PH_MACK_HI: begin
					scl = 1'b1; pull = mk;
				end
				default: begin
					scl = 1'b0; pull = 1'b0;
				end
			endcase

			if (ph == PH_ACK_WAIT) begin
				if (!sda_in) begin
					ph = PH_ACK_LO;
				end else begin
					aw_inc = aw + AW_W'(1);
					aw     = aw_inc;
					if (aw_inc >= ack_limit) begin
						rc = 1'b1;
						ph = PH_ACK_LO;
					end
				end
			end else begin
				dly_inc = {1'b0, dly} + 17'd1;
				dly     = dly_inc[15:0];
				if (dly_inc >= {1'b0, hp}) begin
					unique case (ph)
						PH_START_A: ph = PH_START_B;
						PH_START_B: ph = PH_START_C;
						PH_START_C: begin
							sd   = 1'b1;
							as_n = 1'b1;
							sh   = {target_address_q, (op == i2cm_pkg::FUNC_REQUEST)};
							bi   = i2cm_pkg::BITS_PER_BYTE;
							ph   = PH_WBIT_SET;
						end
						PH_WBIT_SET: ph = PH_WBIT_HI;
						PH_WBIT_HI:  ph = PH_WBIT_LO;
						PH_WBIT_LO: begin
							sh = {sh[6:0], 1'b0};
							bi = (bi != '0) ? bi - 4'd1 : 4'd0;
							ph = (bi != '0) ? PH_WBIT_SET : PH_ACK_SET;
						end
						PH_ACK_SET: ph = PH_ACK_WAIT;
						PH_ACK_LO: begin
							if (rc || op == i2cm_pkg::FUNC_PROBE) begin
								ph = PH_STOP_A;
							end else if (op == i2cm_pkg::FUNC_WRITE) begin
								if (as_n) begin
									as_n = 1'b0;
									sh   = pend;
									bi   = i2cm_pkg::BITS_PER_BYTE;
									ph   = PH_WBIT_SET;
								end else begin
									ph   = PH_IDLE;
									done = 1'b1;
								end
							end else if (op == i2cm_pkg::FUNC_REQUEST && bl != '0) begin
								as_n = 1'b0;
								sh   = '0;
								bi   = i2cm_pkg::BITS_PER_BYTE;
								ph   = PH_RBIT_HI;
							end else begin
								ph = PH_STOP_A;
							end
						end
						PH_RBIT_HI: begin
							sh = {sh[6:0], sda_in};
							ph = PH_RBIT_LO;
						end
						PH_RBIT_LO: begin
							bi = (bi != '0) ? bi - 4'd1 : 4'd0;
							if (bi != '0) begin
								ph = PH_RBIT_HI;
							end else begin
								fctl.push      = 1'b1;
								fctl.push_data = sh;
								bl = (bl != '0) ? bl - 8'd1 : 8'd0;
								mk = (bl != '0);
								ph = PH_MACK_SET;
							end
						end
						PH_MACK_SET: ph = PH_MACK_HI;
						PH_MACK_HI:  ph = PH_MACK_LO;
						PH_MACK_LO: begin
							if (bl != '0) begin
								sh = '0;
								bi = i2cm_pkg::BITS_PER_BYTE;
								ph = PH_RBIT_HI;
							end else begin
								ph = PH_STOP_A;
							end
						end
						PH_STOP_A: ph = PH_STOP_B;
						PH_STOP_B: ph = PH_STOP_C;
						PH_STOP_C: begin
							sd   = 1'b0;
							ph   = PH_IDLE;
							done = 1'b1;
						end
						default: ph = PH_IDLE;
					endcase
				end
			end

			// any segment change restarts the delay and ACK timers
			if (ph != ph_seg) begin
				dly = '0;
				aw  = '0;
			end
			if (done) begin
				stat = rc ? i2cm_pkg::STAT_NACK : i2cm_pkg::STAT_NONE;
			end
		end
	end

	always_comb begin
		fctl_acc      = fctl;
		fctl_acc.push = fctl.push && accept;
		fctl_acc.pop  = fctl.pop && accept;
	end

	i2cm_rxfifo #(
		.DEPTH (RX_DEPTH),
		.LW    (LW)
	) u_rxfifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (fctl_acc),
		.rd_data (rd_data),
		.count   (rx_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_address_q <= i2cm_pkg::TARGET_ADDR_RST;
			half_period_q    <= i2cm_pkg::HALF_PERIOD_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				i2cm_pkg::CFG_TARGET_ADDRESS: target_address_q <= cfg_data[6:0];
				i2cm_pkg::CFG_HALF_PERIOD:    half_period_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			delay_q      <= '0;
			bit_idx_q    <= '0;
			shift_q      <= '0;
			ack_wait_q   <= '0;
			bytes_left_q <= '0;
			start_done_q <= 1'b0;
			pending_q    <= '0;
			cur_op_q     <= i2cm_pkg::FUNC_TICK;
			addr_stage_q <= 1'b0;
			mack_q       <= 1'b0;
			nack_q       <= 1'b0;
			m_valid_q    <= 1'b0;
			scl_q        <= 1'b0;
			pull_q       <= 1'b0;
			busy_q       <= 1'b0;
			done_q       <= 1'b0;
			status_q     <= i2cm_pkg::STAT_NONE;
			popped_q     <= 1'b0;
		end else if (accept) begin
			phase_q      <= ph;
			delay_q      <= dly;
			bit_idx_q    <= bi;
			shift_q      <= sh;
			ack_wait_q   <= aw;
			bytes_left_q <= bl;
			start_done_q <= sd;
			pending_q    <= pend;
			cur_op_q     <= op;
			addr_stage_q <= as_n;
			mack_q       <= mk;
			nack_q       <= rc;
			m_valid_q    <= 1'b1;
			scl_q        <= scl;
			pull_q       <= pull;
			busy_q       <= (ph != PH_IDLE);
			done_q       <= done;
			status_q     <= stat;
			popped_q     <= fctl.pop;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = OUT_W'({start_done_q, rx_count, (popped_q ? rd_data : 8'd0),
		status_q, done_q, busy_q, pull_q, scl_q});

	// a result that reports an ACK failure or shortage always completes a command
	a_status_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && status_q != i2cm_pkg::STAT_NONE |-> done_q)
		else $error("status set without done");

	// bytes are received only while busy, popped only while idle
	a_push_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!(fctl.push && fctl.pop))
		else $error("FIFO push and pop in one tick");

	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		rx_count <= LW'(RX_DEPTH))
		else $error("receive level above depth");

	// a pop result never comes from a busy engine
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept && fctl.pop |=> !busy_q && done_q)
		else $error("pop result while busy");

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Testbench for the I2C master controller: random bus traffic checked against a tick model.
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RX_DEPTH = 16;
	localparam int STALL_LIMIT = 2000;
	localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
	localparam logic [2:0] FUNC_SPARE_7 = 3'd7;

	typedef enum logic [4:0] {
		SEG_IDLE, SEG_START_A, SEG_START_B, SEG_START_C,
		SEG_WBIT_SET, SEG_WBIT_HI, SEG_WBIT_LO,
		SEG_ACK_SET, SEG_ACK_WAIT, SEG_ACK_LO,
		SEG_RBIT_HI, SEG_RBIT_LO,
		SEG_MACK_SET, SEG_MACK_HI, SEG_MACK_LO,
		SEG_STOP_A, SEG_STOP_B, SEG_STOP_C
	} seg_t;

	typedef struct packed {
		logic [2:0] fn;
		logic [7:0] arg;
		logic       sda;
	} tick_t;

	typedef struct packed {
		logic [3:0]        fill;
		logic              bus_up;
		logic [4:0]        level;
		logic [7:0]        pop;
		i2cm_pkg::status_t status;
		logic              done;
		logic              busy;
		logic              pull;
		logic              scl;
	} bus_res_t;

	typedef struct packed {
		logic [6:0]        addr;
		logic [15:0]       hp;
		seg_t              seg;
		logic [15:0]       dly;
		logic [3:0]        nbits;
		logic [7:0]        shreg;
		logic [20:0]       ackw;
		logic [7:0]        rx_left;
		logic              bus_up;
		logic [15:0][7:0]  rxmem;
		logic [3:0]        rxhead;
		logic [4:0]        rxcnt;
		logic [7:0]        wbyte;
		logic [2:0]        op;
		logic              addr_phase;
		logic              ack_level;
		i2cm_pkg::status_t code;
	} bus_model_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [15:0] cfg_data = '0;

	bus_model_t gen_m, chk_m;
	tick_t      tick_q[$];
	bus_res_t   pending_res[$];
	tick_t      next_tick, in_tick;
	bus_res_t   res_now, want, got;
	int         ticks_made = 0;
	int         ticks_checked = 0;
	int         phase_ticks = 0;
	int         errors = 0;
	int         quiet_cycles = 0;
	int         idle_pct = 0;
	int         src_hold = 0;
	int         snk_hold = 0;

	i2c_master_controller #(.RX_DEPTH(RX_DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic bus_model_t enter_seg(input bus_model_t s, input seg_t p);
		bus_model_t n;
		n = s;
		n.seg = p;
		n.dly = '0;
		n.ackw = '0;
		return n;
	endfunction

	function automatic bus_model_t send_byte(input bus_model_t s, input logic [7:0] b);
		bus_model_t n;
		n = enter_seg(s, SEG_WBIT_SET);
		n.shreg = b;
		n.nbits = i2cm_pkg::BITS_PER_BYTE;
		return n;
	endfunction

	// One bus tick: levels of the current segment, then advance.
	function automatic void i2c_tick(input bus_model_t s0, input tick_t t,
			output bus_model_t s, output bus_res_t r);
		logic [16:0] hpe;
		logic        run;
		logic        done;
		logic [3:0]  wr_at;
		s = s0;
		r = '0;
		done = 1'b0;
		run = 1'b0;
		hpe = (s.hp == 0) ? 17'd1 : {1'b0, s.hp};
		if (s.seg == SEG_IDLE) begin
			r.scl = !s.bus_up;
			if (t.fn == i2cm_pkg::FUNC_POP) begin
				if (s.rxcnt != 0) begin
					r.pop = s.rxmem[s.rxhead];
					s.rxhead = s.rxhead + 1'b1;
					s.rxcnt = s.rxcnt - 1'b1;
				end
				done = 1'b1;
			end else if (t.fn == i2cm_pkg::FUNC_REQUEST &&
					s.rxcnt + t.arg > RX_DEPTH) begin
				done = 1'b1;
				r.status = i2cm_pkg::STAT_SHORT;
			end else if (t.fn == i2cm_pkg::FUNC_PROBE || t.fn == i2cm_pkg::FUNC_WRITE ||
					t.fn == i2cm_pkg::FUNC_REQUEST || t.fn == i2cm_pkg::FUNC_STOP) begin
				s.op = t.fn;
				s.code = i2cm_pkg::STAT_NONE;
				s.addr_phase = 1'b0;
				s.wbyte = t.arg;
				if (t.fn == i2cm_pkg::FUNC_STOP) begin
					s = enter_seg(s, SEG_STOP_A);
				end else if (t.fn == i2cm_pkg::FUNC_WRITE && s.bus_up) begin
					s = send_byte(s, t.arg);
				end else begin
					s.rx_left = t.arg;
					s = enter_seg(s, SEG_START_A);
				end
				run = 1'b1;
			end
		end else begin
			run = 1'b1;
		end

		if (run) begin
			case (s.seg)
				SEG_START_A: begin r.scl = 1'b1; r.pull = 1'b0; end
				SEG_START_B: begin r.scl = 1'b1; r.pull = 1'b1; end
				SEG_START_C: begin r.scl = 1'b0; r.pull = 1'b1; end
				SEG_WBIT_SET, SEG_WBIT_LO: begin r.scl = 1'b0; r.pull = !s.shreg[7]; end
				SEG_WBIT_HI: begin r.scl = 1'b1; r.pull = !s.shreg[7]; end
				SEG_ACK_WAIT, SEG_RBIT_HI: begin r.scl = 1'b1; r.pull = 1'b0; end
				SEG_MACK_SET, SEG_MACK_LO: begin r.scl = 1'b0; r.pull = s.ack_level; end
				SEG_MACK_HI: begin r.scl = 1'b1; r.pull = s.ack_level; end
				SEG_STOP_A: begin r.scl = 1'b0; r.pull = 1'b1; end
				SEG_STOP_B: begin r.scl = 1'b1; r.pull = 1'b1; end
				SEG_STOP_C: begin r.scl = 1'b1; r.pull = 1'b0; end
				default: begin r.scl = 1'b0; r.pull = 1'b0; end
			endcase

			if (s.seg == SEG_ACK_WAIT) begin
				if (!t.sda) begin
					s = enter_seg(s, SEG_ACK_LO);
				end else begin
					s.ackw = s.ackw + 1'b1;
					if (s.ackw >= 20 * hpe) begin
						s.code = i2cm_pkg::STAT_NACK;
						s = enter_seg(s, SEG_ACK_LO);
					end
				end
			end else begin
				s.dly = s.dly + 1'b1;
				if (s.dly >= hpe) begin
					case (s.seg)
						SEG_START_A: s = enter_seg(s, SEG_START_B);
						SEG_START_B: s = enter_seg(s, SEG_START_C);
						SEG_START_C: begin
							s.bus_up = 1'b1;
							s.addr_phase = 1'b1;
							s = send_byte(s, {s.addr, s.op == i2cm_pkg::FUNC_REQUEST});
						end
						SEG_WBIT_SET: s = enter_seg(s, SEG_WBIT_HI);
						SEG_WBIT_HI: s = enter_seg(s, SEG_WBIT_LO);
						SEG_WBIT_LO: begin
							s.shreg = {s.shreg[6:0], 1'b0};
							s.nbits = (s.nbits != 0) ? s.nbits - 1'b1 : 4'd0;
							s = enter_seg(s, (s.nbits != 0) ? SEG_WBIT_SET : SEG_ACK_SET);
						end
						SEG_ACK_SET: s = enter_seg(s, SEG_ACK_WAIT);
						SEG_ACK_LO: begin
							if (s.code != i2cm_pkg::STAT_NONE ||
									s.op == i2cm_pkg::FUNC_PROBE) begin
								s = enter_seg(s, SEG_STOP_A);
							end else if (s.op == i2cm_pkg::FUNC_WRITE) begin
								if (s.addr_phase) begin
									s.addr_phase = 1'b0;
									s = send_byte(s, s.wbyte);
								end else begin
									s = enter_seg(s, SEG_IDLE);
									done = 1'b1;
								end
							end else if (s.op == i2cm_pkg::FUNC_REQUEST &&
									s.rx_left != 0) begin
								s.addr_phase = 1'b0;
								s.shreg = '0;
								s.nbits = i2cm_pkg::BITS_PER_BYTE;
								s = enter_seg(s, SEG_RBIT_HI);
							end else begin
								s = enter_seg(s, SEG_STOP_A);
							end
						end
						SEG_RBIT_HI: begin
							s.shreg = {s.shreg[6:0], t.sda};
							s = enter_seg(s, SEG_RBIT_LO);
						end
						SEG_RBIT_LO: begin
							s.nbits = (s.nbits != 0) ? s.nbits - 1'b1 : 4'd0;
							if (s.nbits != 0) begin
								s = enter_seg(s, SEG_RBIT_HI);
							end else begin
								if (s.rxcnt < RX_DEPTH) begin
									wr_at = s.rxhead + s.rxcnt[3:0];
									s.rxmem[wr_at] = s.shreg;
									s.rxcnt = s.rxcnt + 1'b1;
								end
								s.rx_left = (s.rx_left != 0) ? s.rx_left - 1'b1 : 8'd0;
								s.ack_level = (s.rx_left != 0);
								s = enter_seg(s, SEG_MACK_SET);
							end
						end
						SEG_MACK_SET: s = enter_seg(s, SEG_MACK_HI);
						SEG_MACK_HI: s = enter_seg(s, SEG_MACK_LO);
						SEG_MACK_LO: begin
							if (s.rx_left != 0) begin
								s.shreg = '0;
								s.nbits = i2cm_pkg::BITS_PER_BYTE;
								s = enter_seg(s, SEG_RBIT_HI);
							end else begin
								s = enter_seg(s, SEG_STOP_A);
							end
						end
						SEG_STOP_A: s = enter_seg(s, SEG_STOP_B);
						SEG_STOP_B: s = enter_seg(s, SEG_STOP_C);
						SEG_STOP_C: begin
							s.bus_up = 1'b0;
							s = enter_seg(s, SEG_IDLE);
							done = 1'b1;
						end
						default: s = enter_seg(s, SEG_IDLE);
					endcase
				end
			end
			if (done)
				r.status = s.code;
		end

		r.busy = (s.seg != SEG_IDLE);
		r.done = done;
		r.level = s.rxcnt;
		r.bus_up = s.bus_up;
	endfunction

	task automatic put(input logic [2:0] fn, input logic [7:0] arg, input logic sda);
		tick_t    t;
		bus_res_t unused;
		t = {fn, arg, sda};
		i2c_tick(gen_m, t, gen_m, unused);
		tick_q.push_back(t);
		ticks_made++;
		phase_ticks++;
	endtask

	// Issue one request, then tick until the engine is idle again.
	// An absent slave never pulls SDA low during the acknowledge wait.
	task automatic run_cmd(input logic [2:0] fn, input logic [7:0] arg, input logic absent);
		logic [2:0] bf;
		logic       sda;
		put(fn, arg, 1'($urandom_range(0, 1)));
		while (gen_m.seg != SEG_IDLE) begin
			if (gen_m.seg == SEG_ACK_WAIT)
				sda = absent | ($urandom_range(0, 2) != 0);
			else
				sda = 1'($urandom_range(0, 1));
			if ($urandom_range(0, 7) == 0)
				bf = 3'($urandom_range(i2cm_pkg::FUNC_PROBE, FUNC_SPARE_7));
			else
				bf = i2cm_pkg::FUNC_TICK;
			put(bf, 8'($urandom_range(0, 255)), sda);
		end
	endtask

	task automatic random_cmd();
		int         pick;
		int         room;
		logic [2:0] fn;
		logic [7:0] arg;
		pick = $urandom_range(0, 99);
		arg = 8'($urandom_range(0, 255));
		if (pick < 14) begin
			fn = i2cm_pkg::FUNC_PROBE;
		end else if (pick < 36) begin
			fn = i2cm_pkg::FUNC_WRITE;
		end else if (pick < 56) begin
			fn = i2cm_pkg::FUNC_REQUEST;
			room = RX_DEPTH - gen_m.rxcnt;
			if ($urandom_range(0, 3) == 0)
				arg = 8'($urandom_range(0, room));
			else if ($urandom_range(0, 4) != 0)
				arg = 8'($urandom_range(0, (room > 3) ? 3 : room));
		end else if (pick < 76) begin
			fn = i2cm_pkg::FUNC_POP;
		end else if (pick < 86) begin
			fn = i2cm_pkg::FUNC_STOP;
		end else if (pick < 93) begin
			fn = i2cm_pkg::FUNC_TICK;
		end else begin
			fn = 3'($urandom_range(FUNC_SPARE_6, FUNC_SPARE_7));
		end
		run_cmd(fn, arg, $urandom_range(0, 7) == 0);
	endtask

	task automatic drain();
		while (ticks_checked != ticks_made)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == i2cm_pkg::CFG_TARGET_ADDRESS) begin
			gen_m.addr = val[6:0];
			chk_m.addr = val[6:0];
		end else begin
			gen_m.hp = val;
			chk_m.hp = val;
		end
	endtask

	task automatic run_phase(input logic [6:0] a, input logic [15:0] h, input int pct,
			input int budget);
		drain();
		write_reg(i2cm_pkg::CFG_TARGET_ADDRESS, {9'($urandom_range(0, 511)), a});
		write_reg(i2cm_pkg::CFG_HALF_PERIOD, h);
		idle_pct = pct;
		phase_ticks = 0;
		while (phase_ticks < budget)
			random_cmd();
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			src_hold = 0;
		end else if (!s_tvalid || s_tready) begin
			if (src_hold == 0 && idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
				src_hold = $urandom_range(1, 14);
			if (src_hold != 0) begin
				src_hold--;
				s_tvalid <= 1'b0;
			end else if (tick_q.size() != 0) begin
				next_tick = tick_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {7'd0, next_tick.sda, next_tick.arg};
				s_tuser <= next_tick.fn;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			snk_hold = 0;
		end else begin
			if (snk_hold == 0 && idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
				snk_hold = $urandom_range(1, 14);
			if (snk_hold != 0) begin
				snk_hold--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				in_tick = {s_tuser, s_tdata[7:0], s_tdata[8]};
				i2c_tick(chk_m, in_tick, chk_m, res_now);
				pending_res.push_back(res_now);
			end
			if (m_tvalid && m_tready) begin
				got = bus_res_t'(m_tdata);
				if (pending_res.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result %h", m_tdata);
				end else begin
					want = pending_res.pop_front();
					if (m_tdata !== want) begin
						errors++;
						if (errors <= 10) begin
							$display("result %0d: exp scl %b pull %b busy %b done %b st %0d pop %h lvl %0d open %b fill %h",
								ticks_checked, want.scl, want.pull, want.busy, want.done,
								want.status, want.pop, want.level, want.bus_up, want.fill);
							$display("result %0d: got scl %b pull %b busy %b done %b st %0d pop %h lvl %0d open %b fill %h",
								ticks_checked, got.scl, got.pull, got.busy, got.done,
								got.status, got.pop, got.level, got.bus_up, got.fill);
						end
					end
				end
				ticks_checked++;
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= STALL_LIMIT) begin
					$display("[i2c_master_controller] ERROR");
					$finish;
				end
			end
		end
	end

	initial begin
		gen_m = '0;
		gen_m.seg = SEG_IDLE;
		gen_m.code = i2cm_pkg::STAT_NONE;
		gen_m.hp = i2cm_pkg::HALF_PERIOD_RST;
		gen_m.addr = i2cm_pkg::TARGET_ADDR_RST;
		chk_m = gen_m;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset half period: one stop sequence, then a pop
		idle_pct = 20;
		run_cmd(i2cm_pkg::FUNC_STOP, 8'h00, 1'b0);
		run_cmd(i2cm_pkg::FUNC_POP, 8'hFF, 1'b0);
		drain();

		// fast bus, reset target address
		write_reg(i2cm_pkg::CFG_HALF_PERIOD, 16'd1);
		idle_pct = 25;
		run_cmd(i2cm_pkg::FUNC_PROBE, 8'h00, 1'b0);
		drain();

		write_reg(i2cm_pkg::CFG_TARGET_ADDRESS, {9'h1AB, 7'h7F});
		run_cmd(i2cm_pkg::FUNC_PROBE, 8'hFF, 1'b1);
		run_cmd(i2cm_pkg::FUNC_WRITE, 8'hFF, 1'b0);
		run_cmd(i2cm_pkg::FUNC_WRITE, 8'h00, 1'b0);
		run_cmd(i2cm_pkg::FUNC_REQUEST, 8'd2, 1'b0);
		run_cmd(i2cm_pkg::FUNC_WRITE, 8'hA5, 1'b1);
		run_cmd(i2cm_pkg::FUNC_WRITE, 8'h3C, 1'b0);
		run_cmd(i2cm_pkg::FUNC_WRITE, 8'hC3, 1'b1);
		run_cmd(i2cm_pkg::FUNC_REQUEST, 8'd1, 1'b1);
		run_cmd(i2cm_pkg::FUNC_REQUEST, 8'd0, 1'b0);
		run_cmd(i2cm_pkg::FUNC_STOP, 8'h00, 1'b0);
		run_cmd(i2cm_pkg::FUNC_REQUEST, 8'd14, 1'b0);
		run_cmd(i2cm_pkg::FUNC_REQUEST, 8'd1, 1'b0);
		run_cmd(i2cm_pkg::FUNC_REQUEST, 8'd255, 1'b0);
		run_cmd(FUNC_SPARE_6, 8'h5A, 1'b0);
		run_cmd(FUNC_SPARE_7, 8'hA5, 1'b0);
		run_cmd(i2cm_pkg::FUNC_TICK, 8'hFF, 1'b1);
		repeat (17) run_cmd(i2cm_pkg::FUNC_POP, 8'h00, 1'b0);

		run_phase(7'($urandom_range(0, 127)), 16'd1, 30, 60);
		run_phase(7'($urandom_range(0, 127)), 16'd2, 15, 30);
		run_phase(7'h7F, 16'd3, 40, 10);
		run_phase(7'h00, 16'd0, 0, 60);

		// slowest bus, no idling
		run_phase(7'($urandom_range(0, 127)), 16'hFFFF, 0, 0);
		run_cmd(i2cm_pkg::FUNC_POP, 8'h00, 1'b0);
		run_cmd(i2cm_pkg::FUNC_REQUEST, 8'd255, 1'b0);
		run_cmd(i2cm_pkg::FUNC_TICK, 8'h00, 1'b1);
		drain();
		repeat (10) @(posedge clk);

		if (errors == 0)
			$display("[i2c_master_controller] OK");
		else
			$display("[i2c_master_controller] ERROR");
		$finish;
	end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/i2cm_pkg.sv
rtl/i2cm_rxfifo.sv
rtl/i2c_master_controller.sv
tb/testbench.sv
